// File: rtl/core/sxrp_pkg.sv
// Shared types and constants for the extended register port block.
// Holds port codes, index codes, the CRTC write mask table and the
// structs for the CRTC store interface and the top-level response.
package sxrp_pkg;

   localparam int unsigned CRTC_IDX_W = 6;

   // Port decode constants.
   localparam logic [11:0] PORT_HI_MONO  = 12'h03B;
   localparam logic [11:0] PORT_HI_COLOR = 12'h03D;
   localparam logic [15:0] PORT_SWAP     = 16'h0060;

   localparam logic [15:0] PORT_SEQ_INDEX = 16'h03C4;
   localparam logic [15:0] PORT_SEQ_DATA  = 16'h03C5;
   localparam logic [15:0] PORT_GFX_INDEX = 16'h03CE;
   localparam logic [15:0] PORT_GFX_DATA  = 16'h03CF;
   localparam logic [15:0] PORT_CRTC_IDX  = 16'h03D4;
   localparam logic [15:0] PORT_CRTC_DATA = 16'h03D5;
   localparam logic [15:0] PORT_WR_BANK   = 16'h03D8;
   localparam logic [15:0] PORT_RD_BANK   = 16'h03D9;

   // Sequencer and graphics sub-indices.
   localparam logic [3:0] SEQ_MODE_TOGGLE = 4'hB;
   localparam logic [3:0] SEQ_REG_C       = 4'hC;
   localparam logic [3:0] SEQ_CONTROL_TWO = 4'hD;
   localparam logic [3:0] SEQ_REG_E       = 4'hE;
   localparam logic [3:0] GFX_REG_E       = 4'hE;
   localparam logic [3:0] GFX_REG_F       = 4'hF;

   // CRTC indices with special handling.
   localparam logic [CRTC_IDX_W-1:0] CRTC_PROTECT_IDX = 6'h07;
   localparam logic [CRTC_IDX_W-1:0] CRTC_LOCK_IDX    = 6'h11;
   localparam logic [CRTC_IDX_W-1:0] CRTC_CURSOR_LO   = 6'h0E;
   localparam logic [CRTC_IDX_W-1:0] CRTC_CURSOR_HI   = 6'h10;
   localparam logic [CRTC_IDX_W-1:0] CRTC_DUMMY_LO    = 6'h19;
   localparam logic [CRTC_IDX_W-1:0] CRTC_DUMMY_HI    = 6'h1D;
   localparam logic [CRTC_IDX_W-1:0] CRTC_MASK_SEL    = 6'h1E;

   // Configuration register map.
   localparam logic CSR_COLOR_IO = 1'b0;
   localparam logic CSR_CHIP_ID  = 1'b1;
   localparam logic [7:0] CHIP_ID_RESET = 8'd51;

   localparam logic [7:0] BANK_XOR = 8'h02;

   typedef struct packed {
      logic       commit;
      logic       index_wr;
      logic       data_wr;
      logic [7:0] wdata;
   } crtc_cmd_type;

   typedef struct packed {
      logic [7:0] rdata;
      logic       timing_change;
      logic       mask_sel_next;
   } crtc_stat_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       forwarded;
      logic       timing_change;
      logic [4:0] wr_bank_num;
      logic [4:0] rd_bank_num;
      logic       full_display_mask;
   } rsp_type;

   // Bits of each CRTC register that are implemented.
   function automatic logic [7:0] crtc_impl_bits(input logic [CRTC_IDX_W-1:0] idx);
      logic [7:0] m;
      case (idx)
         6'h00, 6'h01, 6'h02, 6'h03, 6'h04, 6'h05, 6'h06, 6'h07: m = 8'hFF;
         6'h08: m = 8'h7F;
         6'h09: m = 8'hFF;
         6'h0A: m = 8'h3F;
         6'h0B: m = 8'h7F;
         6'h0C, 6'h0D, 6'h0E, 6'h0F, 6'h10, 6'h11, 6'h12, 6'h13: m = 8'hFF;
         6'h14: m = 8'h7F;
         6'h15, 6'h16: m = 8'hFF;
         6'h17: m = 8'hEF;
         6'h18: m = 8'hFF;
         6'h1E, 6'h1F: m = 8'hFF;
         6'h20: m = 8'h7F;
         6'h23: m = 8'h2F;
         6'h27: m = 8'h03;
         6'h29: m = 8'h13;
         default: m = 8'h00;
      endcase
      return m;
   endfunction

endpackage

// File: rtl/core/sxrp_if.sv
// Channel interfaces for the request and response sides of the port block.
// Payload widths follow the fixed field widths; no package dependency.
interface sxrp_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [15:0] port_address;
   logic [7:0]  write_data;

   modport source (output valid, mode, port_address, write_data, input ready);
   modport sink (input valid, mode, port_address, write_data, output ready);
endinterface

interface sxrp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       forwarded;
   logic       timing_change;
   logic [4:0] wr_bank_num;
   logic [4:0] rd_bank_num;
   logic       full_display_mask;

   modport source (output valid, read_data, forwarded, timing_change, wr_bank_num,
                   rd_bank_num, full_display_mask, input ready);
   modport sink (input valid, read_data, forwarded, timing_change, wr_bank_num,
                 rd_bank_num, full_display_mask, output ready);
endinterface

// File: rtl/core/sxrp_crtc.sv
// CRTC index register and 64-entry CRTC store with write protection.
// Uses sxrp_pkg for the command and status structs and the mask table.
module sxrp_crtc #(
   parameter int unsigned CRTC_ENTRIES = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sxrp_pkg::crtc_cmd_type       cmd,
   output logic [$clog2(CRTC_ENTRIES)-1:0] index,
   output sxrp_pkg::crtc_stat_type      stat
);
   localparam int unsigned IDX_W = $clog2(CRTC_ENTRIES);

   logic [7:0]              mem [CRTC_ENTRIES];
   logic [CRTC_ENTRIES-1:0] valid_ff;
   logic [7:0]              rd_ff;
   logic [IDX_W-1:0]        index_ff, index_in;
   logic                    protect_ff;
   logic                    mask_sel_ff;
   logic [7:0]              cur;
   logic [7:0]              wval;
   logic [7:0]              masked;
   logic                    locked_out;
   logic                    store_en;
   logic [sxrp_pkg::CRTC_IDX_W-1:0] idx6;

   assign idx6  = sxrp_pkg::CRTC_IDX_W'(index_ff);
   assign index = index_ff;

   // rd_ff always mirrors the entry at index_ff; entries never written read as zero.
   assign cur = valid_ff[index_ff] ? rd_ff : 8'h00;

   always_comb begin
      locked_out = protect_ff && (idx6 < sxrp_pkg::CRTC_PROTECT_IDX);
      wval       = cmd.wdata;
      if (protect_ff && idx6 == sxrp_pkg::CRTC_PROTECT_IDX) begin
         wval = {cur[7:5], cmd.wdata[4], cur[3:0]};
      end
      masked   = wval & sxrp_pkg::crtc_impl_bits(idx6);
      store_en = cmd.data_wr && !locked_out;
      index_in = (cmd.commit && cmd.index_wr) ? cmd.wdata[IDX_W-1:0] : index_ff;

      stat.timing_change = store_en && (masked != cur) &&
                           ((idx6 < sxrp_pkg::CRTC_CURSOR_LO) ||
                            (idx6 > sxrp_pkg::CRTC_CURSOR_HI));
      stat.rdata = ((idx6 >= sxrp_pkg::CRTC_DUMMY_LO) && (idx6 <= sxrp_pkg::CRTC_DUMMY_HI))
                   ? 8'hFF : cur;
      stat.mask_sel_next = (store_en && idx6 == sxrp_pkg::CRTC_MASK_SEL)
                           ? masked[7] : mask_sel_ff;
   end

   // Store array and its registered read port; a write bypasses to the read
   // register because the index cannot change in the same cycle.
   always_ff @(posedge clock) begin
      if (cmd.commit && store_en) begin
         mem[index_ff] <= masked;
         rd_ff         <= masked;
      end else begin
         rd_ff <= mem[index_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         index_ff    <= '0;
         protect_ff  <= 1'b0;
         mask_sel_ff <= 1'b0;
      end else begin
         index_ff    <= index_in;
         if (cmd.commit && store_en) begin
            valid_ff[index_ff] <= 1'b1;
            if (idx6 == sxrp_pkg::CRTC_LOCK_IDX) begin
               protect_ff <= masked[7];
            end
         end
         if (cmd.commit) begin
            mask_sel_ff <= stat.mask_sel_next;
         end
      end
   end

endmodule

// File: rtl/core/svga_extension_register_port.sv
// Extended register port of a VGA-compatible adapter: I/O decode, mode
// toggle, control and bank registers, with the CRTC store in sxrp_crtc.
// A request accepted into the input register is decoded from it, and its
// response is loaded into the response register when the decode stage fires,
// which waits while a held response has not been taken.
// Throughput: one request per cycle while the response register drains;
// the input register, decode logic and response register form a single pass.
// Reset (synchronous, active high) clears all control state, sets color_io
// to 1 and chip_id to 51; unwritten CRTC entries read zero, 0x19-0x1D read 0xFF.
module svga_extension_register_port #(
   parameter int unsigned CRTC_ENTRIES = 64
) (
   input  logic               clock,
   input  logic               reset,
   sxrp_req_if.sink           req_ch,
   sxrp_rsp_if.source         rsp_ch,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   localparam int unsigned IDX_W = $clog2(CRTC_ENTRIES);

   // Configuration registers.
   logic       color_io_ff;
   logic [7:0] chip_id_ff;

   // Input register holding the request being decoded.
   logic        s1_valid_ff;
   logic        s1_mode_ff;
   logic [15:0] s1_port_ff;
   logic [7:0]  s1_data_ff;
   logic        s1_fire;
   logic        out_free;

   // Adapter state. Sequencer register C and graphics register E have no
   // visible effect beyond the bank number, so only that effect is kept.
   logic [7:0] seq_index_ff, seq_index_in;
   logic [7:0] gfx_index_ff, gfx_index_in;
   logic       old_mode_ff, old_mode_in;
   logic [7:0] old_ctl1_ff, old_ctl1_in;
   logic [7:0] old_ctl2_ff, old_ctl2_in;
   logic [7:0] new_ctl2_ff, new_ctl2_in;
   logic [7:0] seq_reg_e_ff, seq_reg_e_in;
   logic [7:0] gfx_reg_f_ff, gfx_reg_f_in;
   logic [7:0] wr_bank_ff, wr_bank_in;
   logic [7:0] rd_bank_ff, rd_bank_in;

   // Response register.
   logic                   rsp_valid_ff;
   sxrp_pkg::rsp_type      rsp_ff, rsp_in;

   logic [15:0]            port_dec;
   logic                   fwd;
   logic [7:0]             rd;
   logic [7:0]             xored;
   sxrp_pkg::crtc_cmd_type crtc_cmd;
   sxrp_pkg::crtc_stat_type crtc_stat;
   logic [IDX_W-1:0]       crtc_index;

   // ------------------------------------------------------------------
   // Configuration port. Only paddr bit 2 selects the register.
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_io_ff <= 1'b1;
         chip_id_ff  <= sxrp_pkg::CHIP_ID_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[2])
            sxrp_pkg::CSR_COLOR_IO: color_io_ff <= csr_pwdata[0];
            sxrp_pkg::CSR_CHIP_ID:  chip_id_ff  <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         sxrp_pkg::CSR_COLOR_IO: csr_prdata = {31'b0, color_io_ff};
         sxrp_pkg::CSR_CHIP_ID:  csr_prdata = {24'b0, chip_id_ff};
         default:                csr_prdata = 32'b0;
      endcase
   end

   // ------------------------------------------------------------------
   // Handshake. The decode stage advances whenever the response register
   // is empty or being drained, so a request can enter every cycle.
   // ------------------------------------------------------------------
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign s1_fire      = s1_valid_ff && out_free;
   assign req_ch.ready = !s1_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         s1_mode_ff <= req_ch.mode;
         s1_port_ff <= req_ch.port_address;
         s1_data_ff <= req_ch.write_data;
      end
   end

   // ------------------------------------------------------------------
   // Decode and next state.
   // ------------------------------------------------------------------
   always_comb begin
      // Mono decoding moves the 0x3Bx and 0x3Dx ranges onto each other.
      port_dec = s1_port_ff;
      if (((s1_port_ff[15:4] == sxrp_pkg::PORT_HI_COLOR) ||
           (s1_port_ff[15:4] == sxrp_pkg::PORT_HI_MONO)) && !color_io_ff) begin
         port_dec = s1_port_ff ^ sxrp_pkg::PORT_SWAP;
      end

      xored = s1_data_ff ^ sxrp_pkg::BANK_XOR;

      seq_index_in = seq_index_ff;
      gfx_index_in = gfx_index_ff;
      old_mode_in  = old_mode_ff;
      old_ctl1_in  = old_ctl1_ff;
      old_ctl2_in  = old_ctl2_ff;
      new_ctl2_in  = new_ctl2_ff;
      seq_reg_e_in = seq_reg_e_ff;
      gfx_reg_f_in = gfx_reg_f_ff;
      wr_bank_in   = wr_bank_ff;
      rd_bank_in   = rd_bank_ff;

      fwd = 1'b1;
      rd  = 8'h00;

      crtc_cmd.commit   = s1_fire;
      crtc_cmd.index_wr = 1'b0;
      crtc_cmd.data_wr  = 1'b0;
      crtc_cmd.wdata    = s1_data_ff;

      if (s1_mode_ff) begin
         case (port_dec)
            sxrp_pkg::PORT_SEQ_INDEX: seq_index_in = s1_data_ff;
            sxrp_pkg::PORT_GFX_INDEX: gfx_index_in = s1_data_ff;
            sxrp_pkg::PORT_SEQ_DATA: begin
               case (seq_index_ff[3:0])
                  sxrp_pkg::SEQ_MODE_TOGGLE: old_mode_in = 1'b1;
                  sxrp_pkg::SEQ_REG_C: ;
                  sxrp_pkg::SEQ_CONTROL_TWO: begin
                     if (old_mode_ff) begin
                        old_ctl2_in = s1_data_ff;
                     end else begin
                        new_ctl2_in = s1_data_ff;
                     end
                  end
                  sxrp_pkg::SEQ_REG_E: begin
                     // New mode stores the value with bit 1 inverted, and
                     // its low nibble becomes the write bank.
                     fwd = 1'b0;
                     if (old_mode_ff) begin
                        old_ctl1_in = s1_data_ff;
                     end else begin
                        seq_reg_e_in = xored;
                        wr_bank_in   = {4'b0, xored[3:0]};
                     end
                  end
                  default: ;
               endcase
            end
            sxrp_pkg::PORT_GFX_DATA: begin
               case (gfx_index_ff[3:0])
                  sxrp_pkg::GFX_REG_E: rd_bank_in   = {4'b0, xored[3:0]};
                  sxrp_pkg::GFX_REG_F: gfx_reg_f_in = s1_data_ff;
                  default: ;
               endcase
            end
            sxrp_pkg::PORT_CRTC_IDX: begin
               fwd               = 1'b0;
               crtc_cmd.index_wr = 1'b1;
            end
            sxrp_pkg::PORT_CRTC_DATA: begin
               fwd              = 1'b0;
               crtc_cmd.data_wr = 1'b1;
            end
            sxrp_pkg::PORT_WR_BANK: begin
               fwd = 1'b0;
               if (gfx_reg_f_ff[2]) begin
                  wr_bank_in = s1_data_ff;
               end
            end
            sxrp_pkg::PORT_RD_BANK: begin
               fwd = 1'b0;
               if (gfx_reg_f_ff[2]) begin
                  rd_bank_in = s1_data_ff;
               end
            end
            default: ;
         endcase
      end else begin
         case (port_dec)
            sxrp_pkg::PORT_SEQ_DATA: begin
               case (seq_index_ff[3:0])
                  sxrp_pkg::SEQ_MODE_TOGGLE: begin
                     // Reading the chip identity switches to new mode.
                     fwd         = 1'b0;
                     rd          = chip_id_ff;
                     old_mode_in = 1'b0;
                  end
                  sxrp_pkg::SEQ_CONTROL_TWO: begin
                     fwd = 1'b0;
                     rd  = old_mode_ff ? old_ctl2_ff : new_ctl2_ff;
                  end
                  sxrp_pkg::SEQ_REG_E: begin
                     if (old_mode_ff) begin
                        fwd = 1'b0;
                        rd  = old_ctl1_ff;
                     end
                  end
                  default: ;
               endcase
            end
            sxrp_pkg::PORT_CRTC_IDX: begin
               fwd = 1'b0;
               rd  = 8'(crtc_index);
            end
            sxrp_pkg::PORT_CRTC_DATA: begin
               fwd = 1'b0;
               rd  = crtc_stat.rdata;
            end
            sxrp_pkg::PORT_WR_BANK: begin
               fwd = 1'b0;
               rd  = wr_bank_ff;
            end
            sxrp_pkg::PORT_RD_BANK: begin
               fwd = 1'b0;
               rd  = rd_bank_ff;
            end
            default: ;
         endcase
      end

      // The response reports the bank state after this request.
      rsp_in.read_data         = fwd ? 8'h00 : rd;
      rsp_in.forwarded         = fwd;
      rsp_in.timing_change     = crtc_stat.timing_change;
      rsp_in.wr_bank_num       = wr_bank_in[4:0];
      rsp_in.rd_bank_num       = gfx_reg_f_in[0] ? rd_bank_in[4:0] : wr_bank_in[4:0];
      rsp_in.full_display_mask = crtc_stat.mask_sel_next;
   end

   sxrp_crtc #(
      .CRTC_ENTRIES (CRTC_ENTRIES)
   ) u_crtc (
      .clock (clock),
      .reset (reset),
      .cmd   (crtc_cmd),
      .index (crtc_index),
      .stat  (crtc_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_index_ff <= '0;
         gfx_index_ff <= '0;
         old_mode_ff  <= 1'b0;
         old_ctl1_ff  <= '0;
         old_ctl2_ff  <= '0;
         new_ctl2_ff  <= '0;
         seq_reg_e_ff <= '0;
         gfx_reg_f_ff <= '0;
         wr_bank_ff   <= '0;
         rd_bank_ff   <= '0;
      end else if (s1_fire) begin
         seq_index_ff <= seq_index_in;
         gfx_index_ff <= gfx_index_in;
         old_mode_ff  <= old_mode_in;
         old_ctl1_ff  <= old_ctl1_in;
         old_ctl2_ff  <= old_ctl2_in;
         new_ctl2_ff  <= new_ctl2_in;
         seq_reg_e_ff <= seq_reg_e_in;
         gfx_reg_f_ff <= gfx_reg_f_in;
         wr_bank_ff   <= wr_bank_in;
         rd_bank_ff   <= rd_bank_in;
      end
   end

   // ------------------------------------------------------------------
   // Response register.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.read_data         = rsp_ff.read_data;
   assign rsp_ch.forwarded         = rsp_ff.forwarded;
   assign rsp_ch.timing_change     = rsp_ff.timing_change;
   assign rsp_ch.wr_bank_num       = rsp_ff.wr_bank_num;
   assign rsp_ch.rd_bank_num       = rsp_ff.rd_bank_num;
   assign rsp_ch.full_display_mask = rsp_ff.full_display_mask;

endmodule
